// File: hdl/binary_arithmetic_bin_decoder_top_assert.svh
// Assertion macros used by the arithmetic decoder back end (cabac_back).
`ifndef BINARY_ARITHMETIC_BIN_DECODER_TOP_ASSERT_SVH
`define BINARY_ARITHMETIC_BIN_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define CABAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CABAC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CABAC_ASSERT(lbl, prop, msg)
`define CABAC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/cabac_pkg.sv
// Package with types, codes and tables of the arithmetic decoder.
package cabac_pkg;

	localparam logic [2:0] ACT_DECISION = 3'd0;
	localparam logic [2:0] ACT_BYPASS   = 3'd1;
	localparam logic [2:0] ACT_TERM     = 3'd2;
	localparam logic [2:0] ACT_START    = 3'd3;
	localparam logic [2:0] ACT_INIT     = 3'd4;

	localparam logic [5:0] QP_RESET = 6'd26;
	localparam logic [5:0] QP_MAX   = 6'd51;
	localparam logic [8:0] RANGE_INIT = 9'd510;

	typedef enum logic [2:0] {
		KIND_DECISION,
		KIND_BYPASS,
		KIND_TERM,
		KIND_START,
		KIND_INIT,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] idx;
		logic       idx_ok;
		logic [8:0] window;
		logic [6:0] init_state;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ
	} back_state_t;

	typedef struct packed {
		logic [8:0] range;
		logic [8:0] offset;
		logic [3:0] shift;
	} renorm_t;

	localparam logic [7:0] LPS_RANGE_TAB [0:63][0:3] = '{
		'{8'd128,8'd176,8'd208,8'd240},'{8'd128,8'd167,8'd197,8'd227},
		'{8'd128,8'd158,8'd187,8'd216},'{8'd123,8'd150,8'd178,8'd205},
		'{8'd116,8'd142,8'd169,8'd195},'{8'd111,8'd135,8'd160,8'd185},
		'{8'd105,8'd128,8'd152,8'd175},'{8'd100,8'd122,8'd144,8'd166},
		'{8'd95,8'd116,8'd137,8'd158},'{8'd90,8'd110,8'd130,8'd150},
		'{8'd85,8'd104,8'd123,8'd142},'{8'd81,8'd99,8'd117,8'd135},
		'{8'd77,8'd94,8'd111,8'd128},'{8'd73,8'd89,8'd105,8'd122},
		'{8'd69,8'd85,8'd100,8'd116},'{8'd66,8'd80,8'd95,8'd110},
		'{8'd62,8'd76,8'd90,8'd104},'{8'd59,8'd72,8'd86,8'd99},
		'{8'd56,8'd69,8'd81,8'd94},'{8'd53,8'd65,8'd77,8'd89},
		'{8'd51,8'd62,8'd73,8'd85},'{8'd48,8'd59,8'd69,8'd80},
		'{8'd46,8'd56,8'd66,8'd76},'{8'd43,8'd53,8'd63,8'd72},
		'{8'd41,8'd50,8'd59,8'd69},'{8'd39,8'd48,8'd56,8'd65},
		'{8'd37,8'd45,8'd54,8'd62},'{8'd35,8'd43,8'd51,8'd59},
		'{8'd33,8'd41,8'd48,8'd56},'{8'd32,8'd39,8'd46,8'd53},
		'{8'd30,8'd37,8'd43,8'd50},'{8'd29,8'd35,8'd41,8'd48},
		'{8'd27,8'd33,8'd39,8'd45},'{8'd26,8'd31,8'd37,8'd43},
		'{8'd24,8'd30,8'd35,8'd41},'{8'd23,8'd28,8'd33,8'd39},
		'{8'd22,8'd27,8'd32,8'd37},'{8'd21,8'd26,8'd30,8'd35},
		'{8'd20,8'd24,8'd29,8'd33},'{8'd19,8'd23,8'd27,8'd31},
		'{8'd18,8'd22,8'd26,8'd30},'{8'd17,8'd21,8'd25,8'd28},
		'{8'd16,8'd20,8'd23,8'd27},'{8'd15,8'd19,8'd22,8'd25},
		'{8'd14,8'd18,8'd21,8'd24},'{8'd14,8'd17,8'd20,8'd23},
		'{8'd13,8'd16,8'd19,8'd22},'{8'd12,8'd15,8'd18,8'd21},
		'{8'd12,8'd14,8'd17,8'd20},'{8'd11,8'd14,8'd16,8'd19},
		'{8'd11,8'd13,8'd15,8'd18},'{8'd10,8'd12,8'd15,8'd17},
		'{8'd10,8'd12,8'd14,8'd16},'{8'd9,8'd11,8'd13,8'd15},
		'{8'd9,8'd11,8'd12,8'd14},'{8'd8,8'd10,8'd12,8'd14},
		'{8'd8,8'd9,8'd11,8'd13},'{8'd7,8'd9,8'd11,8'd12},
		'{8'd7,8'd9,8'd10,8'd12},'{8'd7,8'd8,8'd10,8'd11},
		'{8'd6,8'd8,8'd9,8'd11},'{8'd6,8'd7,8'd9,8'd10},
		'{8'd6,8'd7,8'd8,8'd9},'{8'd2,8'd2,8'd2,8'd2}
	};

	localparam logic [5:0] LPS_NEXT_TAB [0:63] = '{
		6'd0,6'd0,6'd1,6'd2,6'd2,6'd4,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd9,6'd11,6'd11,6'd12,
		6'd13,6'd13,6'd15,6'd15,6'd16,6'd16,6'd18,6'd18,6'd19,6'd19,6'd21,6'd21,6'd22,
		6'd22,6'd23,6'd24,
		6'd24,6'd25,6'd26,6'd26,6'd27,6'd27,6'd28,6'd29,6'd29,6'd30,6'd30,6'd30,6'd31,
		6'd32,6'd32,6'd33,
		6'd33,6'd33,6'd34,6'd34,6'd35,6'd35,6'd35,6'd36,6'd36,6'd36,6'd37,6'd37,6'd37,
		6'd38,6'd38,6'd63
	};

	function automatic renorm_t renorm(input logic [8:0] rng, input logic [8:0] off,
			input logic [8:0] win);
		renorm_t     res;
		logic [3:0]  n;
		logic [17:0] cat;
		n = 4'd9;
		for (int i = 0; i < 9; i++) begin
			if (rng[i]) n = 4'(8 - i);
		end
		cat = {off, win} << n;
		res.range = rng << n;
		res.offset = cat[17:9];
		res.shift = n;
		return res;
	endfunction

endpackage

// File: hdl/cabac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cabac_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/cabac_front.sv
// Front end: input acceptance, action classification, context init and command queue.
module cabac_front #(
	parameter int NUM_CONTEXTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          action,
	input  logic [7:0]          ctx_index,
	input  logic [7:0]          init_value,
	input  logic [8:0]          bit_window,
	input  logic                clearing,
	output logic                cmd_valid,
	output cabac_pkg::cmd_t     cmd,
	input  logic                cmd_pop
);
	import cabac_pkg::*;

	logic [5:0]        slice_qp_q;
	cmd_t              queue_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push;
	cmd_t              new_cmd;
	logic [5:0]        qp;
	logic signed [12:0] m, n, t, pre;

	always_comb begin
		qp = (slice_qp_q > QP_MAX) ? QP_MAX : slice_qp_q;
		m = $signed({9'b0, init_value[7:4]}) * 13'sd5 - 13'sd45;
		n = $signed({6'b0, init_value[3:0], 3'b0}) - 13'sd16;
		t = m * $signed({7'b0, qp});
		pre = (t >>> 4) + n;
		if (pre < 13'sd1) pre = 13'sd1;
		if (pre > 13'sd126) pre = 13'sd126;
		new_cmd.idx = ctx_index;
		new_cmd.idx_ok = 32'(ctx_index) < NUM_CONTEXTS;
		new_cmd.window = bit_window;
		if (pre > 13'sd63) new_cmd.init_state = {6'(pre - 13'sd64), 1'b1};
		else new_cmd.init_state = {6'(13'sd63 - pre), 1'b0};
		unique case (action)
			ACT_DECISION: new_cmd.kind = KIND_DECISION;
			ACT_BYPASS:   new_cmd.kind = KIND_BYPASS;
			ACT_TERM:     new_cmd.kind = KIND_TERM;
			ACT_START:    new_cmd.kind = KIND_START;
			ACT_INIT:     new_cmd.kind = KIND_INIT;
			default:      new_cmd.kind = KIND_NOP;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2) || clearing;
	assign push = in_valid && !in_stall;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_qp_q <= QP_RESET;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (cfg_we) slice_qp_q <= cfg_wdata;
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

// File: hdl/cabac_back.sv
// Back end: arithmetic decoding engine, context store and output register.
`include "binary_arithmetic_bin_decoder_top_assert.svh"
module cabac_back #(
	parameter int NUM_CONTEXTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  cabac_pkg::cmd_t cmd,
	output logic            cmd_pop,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            bin_value,
	output logic [3:0]      bits_used
);
	import cabac_pkg::*;

	localparam int AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

	back_state_t state_q, state_d;
	logic [AW-1:0] clr_cnt_q;
	logic [8:0]    range_q, offset_q, range_d, offset_d;
	logic          out_valid_q, bin_q, bin_d;
	logic [3:0]    used_q, used_d;
	logic          out_free, out_load;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, addr;
	logic [6:0]    ram_wdata, ram_rdata, ctx_s;
	logic [5:0]    p, p_n;
	logic          mps, mps_n;
	logic [7:0]    lps;
	logic [8:0]    rmps, rng_a, off_a, term_r;
	logic [9:0]    byp;
	renorm_t       rn;

	cabac_ram #(.WIDTH(7), .DEPTH(NUM_CONTEXTS)) u_ctx_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(addr), .rdata(ram_rdata)
	);

	assign addr = AW'(cmd.idx);
	assign out_free = !out_valid_q || !out_stall;
	assign clearing = state_q == BK_CLEAR;

	always_comb begin
		ctx_s = cmd.idx_ok ? ram_rdata : 7'd0;
		p = ctx_s[6:1];
		mps = ctx_s[0];
		lps = LPS_RANGE_TAB[p][range_q[7:6]];
		rmps = range_q - {1'b0, lps};
		if (offset_q >= rmps) begin
			off_a = offset_q - rmps;
			rng_a = {1'b0, lps};
			mps_n = (p == 6'd0) ? !mps : mps;
			p_n = LPS_NEXT_TAB[p];
		end else begin
			off_a = offset_q;
			rng_a = rmps;
			mps_n = mps;
			p_n = (p < 6'd62) ? p + 6'd1 : p;
		end
		term_r = range_q - 9'd2;
		byp = {offset_q, cmd.window[8]};
		state_d = state_q;
		range_d = range_q;
		offset_d = offset_q;
		bin_d = 1'b0;
		used_d = 4'd0;
		cmd_pop = 1'b0;
		out_load = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = addr;
		ram_wdata = cmd.init_state;
		rn = renorm(rng_a, off_a, cmd.window);
		unique case (state_q)
			BK_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = 7'd0;
				if (clr_cnt_q == AW'(NUM_CONTEXTS - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					if (cmd.kind == KIND_DECISION) begin
						ram_re = 1'b1;
						state_d = BK_READ;
					end else begin
						cmd_pop = 1'b1;
						out_load = 1'b1;
						unique case (cmd.kind)
							KIND_BYPASS: begin
								used_d = 4'd1;
								if (byp >= {1'b0, range_q}) begin
									bin_d = 1'b1;
									offset_d = 9'(byp - {1'b0, range_q});
								end else begin
									offset_d = byp[8:0];
								end
							end
							KIND_TERM: begin
								if (offset_q >= term_r) begin
									bin_d = 1'b1;
									range_d = term_r;
								end else begin
									rn = renorm(term_r, offset_q, cmd.window);
									range_d = rn.range;
									offset_d = rn.offset;
									used_d = rn.shift;
								end
							end
							KIND_START: begin
								range_d = RANGE_INIT;
								offset_d = cmd.window;
								used_d = 4'd9;
							end
							KIND_INIT: ram_we = cmd.idx_ok;
							default: ;
						endcase
					end
				end
			end
			BK_READ: begin
				cmd_pop = 1'b1;
				out_load = 1'b1;
				bin_d = (offset_q >= rmps) ? !mps : mps;
				ram_we = cmd.idx_ok;
				ram_wdata = {p_n, mps_n};
				range_d = rn.range;
				offset_d = rn.offset;
				used_d = rn.shift;
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_cnt_q <= '0;
			range_q <= RANGE_INIT;
			offset_q <= 9'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (out_load) begin
				range_q <= range_d;
				offset_q <= offset_d;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bin_q <= bin_d;
			used_q <= used_d;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_value = bin_q;
	assign bits_used = used_q;

	`CABAC_ASSERT(a_clear_no_pop, (state_q == BK_CLEAR) |-> !cmd_pop, "Pop during clear")
	`CABAC_ASSERT(a_read_one_cycle, (state_q == BK_READ) |=> (state_q != BK_READ),
		"Context read lasted more than one cycle")
	`CABAC_ASSERT(a_read_has_cmd, (state_q == BK_READ) |-> cmd_valid, "Read without command")
	`CABAC_ASSERT_ALWAYS(a_used_range, out_valid_q |-> (used_q <= 4'd9), "Bits used above nine")
endmodule

// File: hdl/binary_arithmetic_bin_decoder_top.sv
// Top level of the binary arithmetic bin decoder.
// The input channel takes one action word per accepted handshake (in_valid high,
// in_stall low): decision, bypass, terminate, engine start or context init.
// The output channel returns exactly one word per action: the bin and the number
// of look-ahead window bits used, which the caller drops before the next action.
// The slice QP register is to be written with cfg_we only while the block is idle;
// the block does not enforce it. With the engine free, a bypass, terminate, start,
// init or unused action passes the command queue and the output register, while a
// decision also goes through BK_READ, because the context RAM read is registered;
// every other action is handled in BK_IDLE alone.
// After reset the context RAM is cleared one entry per cycle, so in_stall stays
// high until every entry is cleared; range resets to 510 and offset to zero.
// When the receiver stalls, the result stays in the output register and the
// two-entry command queue keeps taking actions until it fills.
module binary_arithmetic_bin_decoder_top #(
	parameter int NUM_CONTEXTS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [7:0] ctx_index,
	input  logic [7:0] init_value,
	input  logic [8:0] bit_window,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       bin_value,
	output logic [3:0] bits_used
);
	import cabac_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_pop, clearing;

	cabac_front #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.ctx_index(ctx_index), .init_value(init_value), .bit_window(bit_window),
		.clearing(clearing), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	cabac_back #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .clearing(clearing), .out_valid(out_valid),
		.out_stall(out_stall), .bin_value(bin_value), .bits_used(bits_used)
	);
endmodule
